@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window mean unit
// Record and result layouts, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WINDOW_MAX = 32;
	localparam int IDX_W      = $clog2(WINDOW_MAX);
	localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
	localparam int LEN_W      = 6;
	localparam int DAY_W      = 16;
	localparam int CNT_W      = 24;
	localparam int SUM_W      = CNT_W + IDX_W;
	localparam int DIV_CNT_W  = $clog2(SUM_W);
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register index, taken from the address bits above the byte offset.
	localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LENGTH = '0;
	localparam logic [LEN_W-1:0]      WINDOW_LENGTH_RESET = LEN_W'(7);

	typedef struct packed {
		logic [DAY_W-1:0] day;
		logic [CNT_W-1:0] new_cases;
		logic [CNT_W-1:0] deaths;
	} item_t;

	typedef struct packed {
		logic [DAY_W-1:0] end_day;
		logic [CNT_W-1:0] avg_cases;
		logic [CNT_W-1:0] avg_deaths;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic div_step;
		logic out_load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic div_last;
	} status_t;

endpackage

@@ rtl/sliding_window_mean_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_mean_unit: moving average over daily records
// Sequence: a record that yields a result passes a window update, 29 division
// steps and a result load, which waits while an earlier result is pending. The
// 29-bit running sums are divided serially, one quotient bit per cycle.
// A new record is taken only once the previous one is through, also while the
// window fills. Reset clears sums, fill count and slot and sets window_length
// to 7; the ring stores are not cleared.
// ----------------------------------------------------------------------------
module sliding_window_mean_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  swm_pkg::item_t                     item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output swm_pkg::result_t                   result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [swm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [swm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [swm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	logic [swm_pkg::LEN_W-1:0] window_length_q;
	logic                      reg_hit;
	logic                      reg_write;
	swm_pkg::cmd_t             ctrl_cmd;
	swm_pkg::cmd_t             cmd;
	swm_pkg::status_t          status;

	assign pready    = 1'b1;
	assign reg_hit   = paddr[swm_pkg::APB_ADDR_W-1:2] == swm_pkg::REG_WINDOW_LENGTH;
	assign reg_write = psel && penable && pwrite && reg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= swm_pkg::WINDOW_LENGTH_RESET;
		end else if (reg_write) begin
			window_length_q <= pwdata[swm_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = swm_pkg::APB_DATA_W'(window_length_q);
		end
	end

	// A length write restarts the window.
	always_comb begin
		cmd       = ctrl_cmd;
		cmd.clear = reg_write;
	end

	swm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (ctrl_cmd)
	);

	swm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.window_length (window_length_q),
		.item          (item),
		.status        (status),
		.result        (result)
	);

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item_ready stayed high after a transfer");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.out_load))
		else $error("result_valid rose without a result load");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid || result_ready))
		else $error("result register loaded while a result was pending");

	a_update_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.update)
		else $error("window update did not follow an accepted record");

endmodule

@@ rtl/swm_dp.sv @@
// ----------------------------------------------------------------------------
// swm_dp: datapath of the sliding window mean unit
// Ring stores for both counts, running sums, fill count, write slot, a pair
// of bit-serial restoring dividers and the result register.
// ----------------------------------------------------------------------------
module swm_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  swm_pkg::cmd_t            cmd,
	input  logic [swm_pkg::LEN_W-1:0] window_length,
	input  swm_pkg::item_t           item,
	output swm_pkg::status_t         status,
	output swm_pkg::result_t         result
);

	logic [swm_pkg::CNT_W-1:0]     case_mem  [swm_pkg::WINDOW_MAX];
	logic [swm_pkg::CNT_W-1:0]     death_mem [swm_pkg::WINDOW_MAX];

	logic [swm_pkg::LEN_W-1:0]     len_eff;
	logic [swm_pkg::IDX_W-1:0]     slot_eff;
	logic                          full;
	logic [swm_pkg::LEN_W:0]       slot_inc;
	logic [swm_pkg::SUM_W-1:0]     case_sum_next;
	logic [swm_pkg::SUM_W-1:0]     death_sum_next;

	logic [swm_pkg::SUM_W-1:0]     case_sum_q;
	logic [swm_pkg::SUM_W-1:0]     death_sum_q;
	logic [swm_pkg::FILL_W-1:0]    fill_q;
	logic [swm_pkg::IDX_W-1:0]     write_slot_q;

	logic [swm_pkg::DAY_W-1:0]     day_q;
	logic [swm_pkg::CNT_W-1:0]     cases_q;
	logic [swm_pkg::CNT_W-1:0]     deaths_q;
	logic [swm_pkg::CNT_W-1:0]     old_case_q;
	logic [swm_pkg::CNT_W-1:0]     old_death_q;
	logic [swm_pkg::IDX_W-1:0]     slot_q;
	logic [swm_pkg::LEN_W-1:0]     len_q;

	logic [swm_pkg::SUM_W-1:0]     case_quo_q;
	logic [swm_pkg::SUM_W-1:0]     death_quo_q;
	logic [swm_pkg::LEN_W-1:0]     case_rem_q;
	logic [swm_pkg::LEN_W-1:0]     death_rem_q;
	logic [swm_pkg::DIV_CNT_W-1:0] div_cnt_q;

	swm_pkg::result_t              result_q;

	// One restoring step: shift in the next dividend bit, subtract when possible.
	// Returns {remainder, quotient bit}.
	function automatic logic [swm_pkg::LEN_W:0] div_step_f(
		input logic [swm_pkg::LEN_W-1:0] rem,
		input logic                      din,
		input logic [swm_pkg::LEN_W-1:0] len
	);
		logic [swm_pkg::LEN_W:0] trial;
		trial = {rem, din};
		if (trial >= {1'b0, len}) begin
			trial = trial - {1'b0, len};
			div_step_f = {trial[swm_pkg::LEN_W-1:0], 1'b1};
		end else begin
			div_step_f = {trial[swm_pkg::LEN_W-1:0], 1'b0};
		end
	endfunction

	logic [swm_pkg::LEN_W:0] case_step;
	logic [swm_pkg::LEN_W:0] death_step;

	always_comb begin
		if (window_length == '0) begin
			len_eff = swm_pkg::LEN_W'(1);
		end else if (window_length > swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX)) begin
			len_eff = swm_pkg::LEN_W'(swm_pkg::WINDOW_MAX);
		end else begin
			len_eff = window_length;
		end
		if (swm_pkg::LEN_W'(write_slot_q) >= len_eff) begin
			slot_eff = '0;
		end else begin
			slot_eff = write_slot_q;
		end
	end

	always_comb begin
		full     = swm_pkg::LEN_W'(fill_q) >= len_q;
		slot_inc = (swm_pkg::LEN_W+1)'(slot_q) + (swm_pkg::LEN_W+1)'(1);
		case_sum_next  = case_sum_q + swm_pkg::SUM_W'(cases_q);
		death_sum_next = death_sum_q + swm_pkg::SUM_W'(deaths_q);
		if (full) begin
			case_sum_next  = case_sum_next - swm_pkg::SUM_W'(old_case_q);
			death_sum_next = death_sum_next - swm_pkg::SUM_W'(old_death_q);
		end
		status.emit     = full ||
			(swm_pkg::LEN_W'(fill_q) + swm_pkg::LEN_W'(1) >= len_q);
		status.div_last = div_cnt_q == swm_pkg::DIV_CNT_W'(swm_pkg::SUM_W - 1);
		case_step  = div_step_f(case_rem_q, case_quo_q[swm_pkg::SUM_W-1], len_q);
		death_step = div_step_f(death_rem_q, death_quo_q[swm_pkg::SUM_W-1], len_q);
	end

	// The old entry is read at accept; it is only used once the window is full,
	// so the slot has always been written in the current window by then.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			old_case_q  <= case_mem[slot_eff];
			old_death_q <= death_mem[slot_eff];
		end
		if (cmd.update) begin
			case_mem[slot_q]  <= cases_q;
			death_mem[slot_q] <= deaths_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_sum_q   <= '0;
			death_sum_q  <= '0;
			fill_q       <= '0;
			write_slot_q <= '0;
		end else if (cmd.clear) begin
			case_sum_q   <= '0;
			death_sum_q  <= '0;
			fill_q       <= '0;
			write_slot_q <= '0;
		end else if (cmd.update) begin
			case_sum_q  <= case_sum_next;
			death_sum_q <= death_sum_next;
			if (!full) begin
				fill_q <= fill_q + swm_pkg::FILL_W'(1);
			end
			if (slot_inc >= (swm_pkg::LEN_W+1)'(len_q)) begin
				write_slot_q <= '0;
			end else begin
				write_slot_q <= slot_inc[swm_pkg::IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			day_q    <= item.day;
			cases_q  <= item.new_cases;
			deaths_q <= item.deaths;
			slot_q   <= slot_eff;
			len_q    <= len_eff;
		end
		if (cmd.update) begin
			case_quo_q  <= case_sum_next;
			death_quo_q <= death_sum_next;
			case_rem_q  <= '0;
			death_rem_q <= '0;
			div_cnt_q   <= '0;
		end else if (cmd.div_step) begin
			case_quo_q  <= {case_quo_q[swm_pkg::SUM_W-2:0], case_step[0]};
			death_quo_q <= {death_quo_q[swm_pkg::SUM_W-2:0], death_step[0]};
			case_rem_q  <= case_step[swm_pkg::LEN_W:1];
			death_rem_q <= death_step[swm_pkg::LEN_W:1];
			div_cnt_q   <= div_cnt_q + swm_pkg::DIV_CNT_W'(1);
		end
		if (cmd.out_load) begin
			result_q.end_day    <= day_q;
			result_q.avg_cases  <= case_quo_q[swm_pkg::CNT_W-1:0];
			result_q.avg_deaths <= death_quo_q[swm_pkg::CNT_W-1:0];
		end
	end

	assign result = result_q;

endmodule

@@ rtl/swm_ctrl.sv @@
// ----------------------------------------------------------------------------
// swm_ctrl: controller of the sliding window mean unit
// Sequences accept, window update, serial division and result load, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module swm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  swm_pkg::status_t  status,
	output swm_pkg::cmd_t     cmd
);

	swm_pkg::state_t state_q;
	swm_pkg::state_t state_next;
	logic            result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next   = state_q;
		item_ready   = 1'b0;
		cmd.accept   = 1'b0;
		cmd.update   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.out_load = 1'b0;
		cmd.clear    = 1'b0;
		case (state_q)
			swm_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_next = swm_pkg::ST_UPDATE;
				end
			end
			swm_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_next = status.emit ? swm_pkg::ST_DIVIDE : swm_pkg::ST_IDLE;
			end
			swm_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_next = swm_pkg::ST_OUTPUT;
				end
			end
			swm_pkg::ST_OUTPUT: begin
				// Wait until the result register is free or being emptied.
				if (!result_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_next   = swm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = swm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

endmodule

@@ verif/tb_sliding_window_mean_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_mean_unit: self-checking bench for the moving average unit
// A queue-fed driver sends daily records while a clocked monitor keeps its own
// copy of the window, predicts each mean and compares every result transfer.
// The window length is rewritten between phases that vary the idling.
// ----------------------------------------------------------------------------
module tb_sliding_window_mean_unit;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          QUIET_CYCLES = 40;
	localparam logic [swm_pkg::APB_ADDR_W-3:0] REG_SPARE = 1'b1;
	localparam logic [swm_pkg::CNT_W-1:0]      COUNT_MAX = '1;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           item_valid = 1'b0;
	logic                           item_ready;
	swm_pkg::item_t                 item = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	swm_pkg::result_t               result;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [swm_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [swm_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [swm_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	swm_pkg::item_t   record_queue[$];
	swm_pkg::result_t pending_means[$];
	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      errors = 0;
	int      cycles = 0;

	// Shadow of the window state inside the block.
	logic [swm_pkg::CNT_W-1:0] case_ring[swm_pkg::WINDOW_MAX];
	logic [swm_pkg::CNT_W-1:0] death_ring[swm_pkg::WINDOW_MAX];
	logic [swm_pkg::SUM_W-1:0] case_total;
	logic [swm_pkg::SUM_W-1:0] death_total;
	int unsigned               filled;
	int unsigned               next_slot;
	logic [swm_pkg::LEN_W-1:0] win_len;

	sliding_window_mean_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void clear_window();
		case_total = '0;
		death_total = '0;
		filled = 0;
		next_slot = 0;
	endfunction

	function automatic logic [swm_pkg::CNT_W-1:0] random_count();
		case ($urandom_range(7))
			0: return '0;
			1: return COUNT_MAX;
			default: return swm_pkg::CNT_W'($urandom);
		endcase
	endfunction

	function automatic swm_pkg::item_t random_record();
		swm_pkg::item_t rec;
		rec.day = ($urandom_range(15) == 0) ? '1 : swm_pkg::DAY_W'($urandom);
		rec.new_cases = random_count();
		rec.deaths = random_count();
		return rec;
	endfunction

	function automatic swm_pkg::item_t make_record(int d, logic [swm_pkg::CNT_W-1:0] c,
		logic [swm_pkg::CNT_W-1:0] k);
		swm_pkg::item_t rec;
		rec.day = swm_pkg::DAY_W'(d);
		rec.new_cases = c;
		rec.deaths = k;
		return rec;
	endfunction

	// Driver: a new record goes out once the previous one has transferred.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (record_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				item <= record_queue.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks result transfers, then updates the shadow window with
	// any register write or record transfer seen at the same edge.
	always @(posedge clk or negedge arst_n) begin
		int unsigned      len;
		int unsigned      s;
		swm_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			win_len = swm_pkg::WINDOW_LENGTH_RESET;
			clear_window();
		end else begin
			if (result_valid && result_ready) begin
				if (pending_means.size() == 0) begin
					$error("unexpected result transfer: end_day %0d", result.end_day);
					errors++;
				end else begin
					want = pending_means.pop_front();
					if (result.end_day !== want.end_day) begin
						$error("end_day: expected %0d, got %0d", want.end_day, result.end_day);
						errors++;
					end
					if (result.avg_cases !== want.avg_cases) begin
						$error("avg_cases: expected %0d, got %0d", want.avg_cases,
							result.avg_cases);
						errors++;
					end
					if (result.avg_deaths !== want.avg_deaths) begin
						$error("avg_deaths: expected %0d, got %0d", want.avg_deaths,
							result.avg_deaths);
						errors++;
					end
				end
			end

			if (psel && penable && pwrite && pready
				&& paddr[swm_pkg::APB_ADDR_W-1:2] == swm_pkg::REG_WINDOW_LENGTH) begin
				win_len = pwdata[swm_pkg::LEN_W-1:0];
				clear_window();
			end

			if (item_valid && item_ready) begin
				len = (win_len == 0) ? 1 : win_len;
				if (len > swm_pkg::WINDOW_MAX)
					len = swm_pkg::WINDOW_MAX;
				s = (next_slot >= len) ? 0 : next_slot;
				// A full window drops its oldest record before taking the new one.
				if (filled >= len) begin
					case_total = case_total - case_ring[s];
					death_total = death_total - death_ring[s];
				end else begin
					filled++;
				end
				case_ring[s] = item.new_cases;
				death_ring[s] = item.deaths;
				case_total = case_total + item.new_cases;
				death_total = death_total + item.deaths;
				next_slot = (s + 1 >= len) ? 0 : s + 1;
				if (filled >= len) begin
					want.end_day = item.day;
					want.avg_cases = swm_pkg::CNT_W'(case_total / len);
					want.avg_deaths = swm_pkg::CNT_W'(death_total / len);
					pending_means.push_back(want);
				end
			end

			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic apb_transfer(input bit wr, input logic [swm_pkg::APB_ADDR_W-3:0] index,
		input logic [swm_pkg::APB_DATA_W-1:0] data,
		output logic [swm_pkg::APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {index, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_length(input logic [swm_pkg::LEN_W-1:0] value);
		logic [swm_pkg::APB_DATA_W-1:0] rdata;
		apb_transfer(1'b0, swm_pkg::REG_WINDOW_LENGTH, '0, rdata);
		if (rdata !== swm_pkg::APB_DATA_W'(value)) begin
			$error("window_length: expected %0d, got %0d", value, rdata);
			errors++;
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (record_queue.size() != 0 || item_valid || pending_means.size() != 0);
	endtask

	// Records that fill the window yield nothing, so the block may still be
	// busy after the last result; give it quiet time before touching registers.
	task automatic settle();
		wait_drained();
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [swm_pkg::LEN_W-1:0] len, input int send_pct,
		input int stall, input int count, input bit pause_midway);
		logic [swm_pkg::APB_DATA_W-1:0] rdata;
		settle();
		apb_transfer(1'b1, swm_pkg::REG_WINDOW_LENGTH, swm_pkg::APB_DATA_W'(len), rdata);
		check_length(len);
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				wait_drained();
			record_queue.push_back(random_record());
		end
	endtask

	initial begin
		logic [swm_pkg::APB_DATA_W-1:0] rdata;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_length(swm_pkg::WINDOW_LENGTH_RESET);

		// Directed records at the reset length of seven.
		@(negedge clk);
		for (int i = 0; i < 7; i++)
			record_queue.push_back(make_record((i == 6) ? 65535 : i, COUNT_MAX, COUNT_MAX));
		for (int i = 0; i < 7; i++)
			record_queue.push_back(make_record(100 + i, '0, '0));
		for (int i = 0; i < 4; i++)
			record_queue.push_back(make_record(200 + i, i[0] ? '0 : COUNT_MAX,
				i[0] ? COUNT_MAX : '0));
		record_queue.push_back(make_record(0, swm_pkg::CNT_W'(1), swm_pkg::CNT_W'(2)));
		record_queue.push_back(make_record(0, swm_pkg::CNT_W'(3), swm_pkg::CNT_W'(5)));
		record_queue.push_back(make_record(65535, swm_pkg::CNT_W'(6), swm_pkg::CNT_W'(13)));
		record_queue.push_back(make_record(32768, 24'h800000, 24'h7FFFFF));

		// A write to an unmapped register must leave the window running.
		settle();
		apb_transfer(1'b1, REG_SPARE, $urandom, rdata);
		@(negedge clk);
		for (int i = 0; i < 10; i++)
			record_queue.push_back(random_record());

		run_phase(swm_pkg::LEN_W'(0), 0, 0, 50, 1'b0);
		run_phase(swm_pkg::LEN_W'(32), 63, 0, 80, 1'b1);
		run_phase(swm_pkg::LEN_W'(20), 0, 0, 10, 1'b0);
		run_phase(swm_pkg::LEN_W'($urandom_range(31, 2)), 0, 63, 80, 1'b0);
		run_phase(swm_pkg::LEN_W'(63), 25, 25, 70, 1'b0);
		run_phase(swm_pkg::LEN_W'(1), 25, 25, 50, 1'b0);
		run_phase(swm_pkg::LEN_W'($urandom_range(62, 33)), 0, 0, 40, 1'b0);
		run_phase(swm_pkg::LEN_W'($urandom_range(16, 2)), 0, 63, 50, 1'b0);

		settle();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
